### rtl/core/audio_specific_config_parser_defines.svh
// Assertion macros shared by the checker of the configuration parser.
// Needs nothing else; included by the files that assert.
`ifndef AUDIO_SPECIFIC_CONFIG_PARSER_DEFINES_SVH
`define AUDIO_SPECIFIC_CONFIG_PARSER_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define ASC_ASSERT_GATED(lbl, clk_s, rst_s, prop_s, msg_s) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop_s) \
    else $error(msg_s);

// Property checked at every clock edge, reset included.
`define ASC_ASSERT_ALWAYS(lbl, clk_s, prop_s, msg_s) \
  lbl: assert property (@(posedge clk_s) prop_s) \
    else $error(msg_s);

`endif

### rtl/core/asc_pkg.sv
`timescale 1ns / 1ps
// Package of the configuration parser: widths, codes, parse phases and lookup functions.
// Depends on nothing; used by every other file of the block but the assertion macros header.
package asc_pkg;

  localparam int MAX_RECORD_BYTES_DEF = 64;

  // Field widths of the record bytes, the length register and the decoded result.
  localparam int DATA_W   = 8;
  localparam int LEN_W    = 7;
  localparam int OBJ_W    = 5;
  localparam int RATE_W   = 24;
  localparam int CHAN_W   = 4;
  localparam int SBR_W    = 2;
  localparam int DELAY_W  = 14;
  localparam int LAYER_W  = 3;
  localparam int SUBS_W   = 5;
  localparam int LLEN_W   = 11;
  localparam int RESIL_W  = 4;

  // Parser internals: bit position (a record is never read past bit 119),
  // field accumulator and remaining-bit counter.
  localparam int POS_W = 8;
  localparam int ACC_W = 24;
  localparam int CNT_W = 5;

  localparam logic [LEN_W-1:0] CFG_LEN_RESET = 7'd2;
  localparam logic [LEN_W-1:0] MIN_LEN       = 7'd2;

  localparam logic [3:0]  SFI_EXPLICIT = 4'hF;
  localparam logic [10:0] SYNC_WORD    = 11'h2b7;
  localparam logic [1:0]  EP_DIRECT    = 2'd3;

  localparam logic [SBR_W-1:0] SBR_UNKNOWN = 2'b11;
  localparam logic [SBR_W-1:0] SBR_YES     = 2'b01;
  localparam logic [SBR_W-1:0] SBR_BAD     = 2'b10;

  // Audio object types that steer the parse.
  localparam logic [OBJ_W-1:0] AOT_AAC_MAIN  = 5'd1;
  localparam logic [OBJ_W-1:0] AOT_AAC_LC    = 5'd2;
  localparam logic [OBJ_W-1:0] AOT_AAC_SSR   = 5'd3;
  localparam logic [OBJ_W-1:0] AOT_AAC_LTP   = 5'd4;
  localparam logic [OBJ_W-1:0] AOT_SBR       = 5'd5;
  localparam logic [OBJ_W-1:0] AOT_AAC_SCAL  = 5'd6;
  localparam logic [OBJ_W-1:0] AOT_TWINVQ    = 5'd7;
  localparam logic [OBJ_W-1:0] AOT_ER_LC     = 5'd17;
  localparam logic [OBJ_W-1:0] AOT_ER_LTP    = 5'd19;
  localparam logic [OBJ_W-1:0] AOT_ER_SCAL   = 5'd20;
  localparam logic [OBJ_W-1:0] AOT_ER_TWINVQ = 5'd21;
  localparam logic [OBJ_W-1:0] AOT_ER_BSAC   = 5'd22;
  localparam logic [OBJ_W-1:0] AOT_ER_LD     = 5'd23;
  localparam logic [OBJ_W-1:0] AOT_ER_PARAM  = 5'd27;

  typedef enum logic [4:0] {
    P_IDLE, P_OBJ, P_SFI, P_RATE, P_CHAN, P_XSFI, P_XRATE, P_OBJ2,
    P_GA_CHECK, P_FLEN, P_DELAY_FLAG, P_DELAY, P_EXT_FLAG, P_LAYER, P_GA_EXT,
    P_SUBS, P_LLEN, P_RESIL, P_FLAG3, P_EP_CHECK, P_EP, P_DM, P_SYNC_CHECK,
    P_SYNC, P_XOBJ, P_SBR, P_XSFI2, P_XRATE2, P_DONE
  } phase_t;

  // A complete record handed from the byte collector to the parser.
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
  } job_t;

  // Parser tells the collector that a record bank may be refilled.
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  function automatic logic [RATE_W-1:0] rate_lookup(input logic [3:0] idx);
    logic [RATE_W-1:0] r;
    unique case (idx)
      4'd0:    r = 24'd96000;
      4'd1:    r = 24'd88200;
      4'd2:    r = 24'd64000;
      4'd3:    r = 24'd48000;
      4'd4:    r = 24'd44100;
      4'd5:    r = 24'd32000;
      4'd6:    r = 24'd24000;
      4'd7:    r = 24'd22050;
      4'd8:    r = 24'd16000;
      4'd9:    r = 24'd12000;
      4'd10:   r = 24'd11025;
      4'd11:   r = 24'd8000;
      4'd12:   r = 24'd7350;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Number of bits a phase reads; zero for the decision and control phases.
  function automatic logic [CNT_W-1:0] field_width(input phase_t ph);
    logic [CNT_W-1:0] w;
    unique case (ph)
      P_OBJ, P_OBJ2, P_SUBS, P_XOBJ:          w = 5'd5;
      P_SFI, P_CHAN, P_XSFI, P_XSFI2:         w = 5'd4;
      P_RATE, P_XRATE, P_XRATE2:              w = 5'd24;
      P_FLEN, P_DELAY_FLAG, P_EXT_FLAG:       w = 5'd1;
      P_FLAG3, P_SBR:                         w = 5'd1;
      P_DELAY:                                w = 5'd14;
      P_LAYER, P_RESIL:                       w = 5'd3;
      P_LLEN, P_SYNC:                         w = 5'd11;
      P_EP, P_DM:                             w = 5'd2;
      default:                                w = '0;
    endcase
    return w;
  endfunction

  function automatic logic has_ga_config(input logic [OBJ_W-1:0] t);
    return (t == AOT_AAC_MAIN) || (t == AOT_AAC_LC) || (t == AOT_AAC_SSR) ||
           (t == AOT_AAC_LTP) || (t == AOT_AAC_SCAL) || (t == AOT_TWINVQ) ||
           (t == AOT_ER_LC) || (t == AOT_ER_LTP) || (t == AOT_ER_SCAL) ||
           (t == AOT_ER_TWINVQ) || (t == AOT_ER_BSAC) || (t == AOT_ER_LD);
  endfunction

  function automatic logic has_ep_config(input logic [OBJ_W-1:0] t);
    return (t == AOT_ER_LC) || ((t >= AOT_ER_LTP) && (t <= AOT_ER_PARAM));
  endfunction

  function automatic logic has_resil_flags(input logic [OBJ_W-1:0] t);
    return (t == AOT_ER_LC) || (t == AOT_ER_LTP) || (t == AOT_ER_SCAL) ||
           (t == AOT_ER_LD);
  endfunction

endpackage

### rtl/core/asc_ifs.sv
`timescale 1ns / 1ps
// Stream interfaces of the configuration parser: record bytes in, decoded fields out.
// Depends on asc_pkg for the field widths.
interface asc_in_if;
  logic                        valid;
  logic                        ready;
  logic [asc_pkg::DATA_W-1:0]  data_byte;
  logic                        first_byte;

  modport source(output valid, output data_byte, output first_byte, input ready);
  modport sink(input valid, input data_byte, input first_byte, output ready);
endinterface

interface asc_out_if;
  logic                                valid;
  logic                                ready;
  logic [asc_pkg::OBJ_W-1:0]           object_type;
  logic [asc_pkg::RATE_W-1:0]          sample_rate;
  logic [asc_pkg::CHAN_W-1:0]          channel_setup;
  logic signed [asc_pkg::SBR_W-1:0]    sbr_present;
  logic [asc_pkg::RATE_W-1:0]          ext_sample_rate;
  logic [asc_pkg::OBJ_W-1:0]           ext_object_type;
  logic [asc_pkg::DELAY_W-1:0]         core_delay;
  logic [asc_pkg::LAYER_W-1:0]         layer_number;
  logic [asc_pkg::SUBS_W-1:0]          sub_frame_count;
  logic [asc_pkg::LLEN_W-1:0]          layer_len;
  logic [asc_pkg::RESIL_W-1:0]         resilience_bits;
  logic                                status;

  modport source(output valid, output object_type, output sample_rate,
                 output channel_setup, output sbr_present, output ext_sample_rate,
                 output ext_object_type, output core_delay, output layer_number,
                 output sub_frame_count, output layer_len, output resilience_bits,
                 output status, input ready);
  modport sink(input valid, input object_type, input sample_rate,
               input channel_setup, input sbr_present, input ext_sample_rate,
               input ext_object_type, input core_delay, input layer_number,
               input sub_frame_count, input layer_len, input resilience_bits,
               input status, output ready);
endinterface

### rtl/core/audio_specific_config_parser.sv
`timescale 1ns / 1ps
// Top level of the MPEG-4 audio-specific configuration parser.
// Depends on asc_pkg, asc_ifs, asc_front, asc_job_queue and asc_back.

// Record bytes are taken one per cycle, while the collector is ready, into one of
// two record banks; when the byte count reaches the configured length the record
// is queued and the parser decodes it while the collector fills the other bank.
// The parser reads one bit per cycle in its field phases and pauses at each
// decision point without reading; that bit loop sets the sustained rate for short
// records. The collector stalls only while both banks hold records not yet handed
// to the output register, and a decoded result waits in that register without
// holding up the next parse.
module audio_specific_config_parser #(
  parameter int MAX_RECORD_BYTES = asc_pkg::MAX_RECORD_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [asc_pkg::LEN_W-1:0]  cfg_wr_data,
  asc_in_if.sink                     byte_stream,
  asc_out_if.source                  result
);
  import asc_pkg::*;

  localparam int IDX_W = $clog2(MAX_RECORD_BYTES);

  logic              push_valid;
  logic              push_ready;
  job_t              push_job;
  logic              pop_valid;
  logic              pop_ready;
  job_t              pop_job;
  rel_t              rel;
  logic [IDX_W:0]    rd_addr;
  logic [DATA_W-1:0] rd_data;

  asc_front #(
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES),
    .IDX_W            (IDX_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_stream (byte_stream),
    .job_valid   (push_valid),
    .job         (push_job),
    .job_ready   (push_ready),
    .rel         (rel),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  asc_job_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job),
    .pop_ready  (pop_ready)
  );

  asc_back #(
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES),
    .IDX_W            (IDX_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (pop_valid),
    .job       (pop_job),
    .job_pop   (pop_ready),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .rel       (rel),
    .result    (result)
  );

endmodule

### rtl/core/asc_front.sv
`timescale 1ns / 1ps
// Byte collector: length register, two record banks in one memory, completion detect.
// Depends on asc_pkg and asc_in_if.
module asc_front #(
  parameter int MAX_RECORD_BYTES = asc_pkg::MAX_RECORD_BYTES_DEF,
  parameter int IDX_W            = $clog2(MAX_RECORD_BYTES)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [asc_pkg::LEN_W-1:0]   cfg_wr_data,
  asc_in_if.sink                      byte_stream,
  output logic                        job_valid,
  output asc_pkg::job_t               job,
  input  logic                        job_ready,
  input  asc_pkg::rel_t               rel,
  input  logic [IDX_W:0]              rd_addr,
  output logic [asc_pkg::DATA_W-1:0]  rd_data
);
  import asc_pkg::*;

  localparam int CNT_BW = $clog2(MAX_RECORD_BYTES + 1);
  localparam int CMP_W  = LEN_W + 1;
  localparam int DEPTH  = 2 * MAX_RECORD_BYTES;
  localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_RECORD_BYTES);

  logic [LEN_W-1:0]  cfg_len;
  logic [LEN_W-1:0]  cap_len;
  logic [LEN_W-1:0]  eff_len;
  logic [CNT_BW-1:0] count;
  logic [CNT_BW-1:0] base;
  logic [CNT_BW-1:0] count_inc;
  logic              fill_bank;
  logic [1:0]        busy;
  logic              accept;
  logic              done;
  logic [DATA_W-1:0] mem [DEPTH];

  always_comb begin
    cap_len = ({1'b0, cfg_len} > MAX_LEN) ? MAX_LEN[LEN_W-1:0] : cfg_len;
    eff_len = (cap_len < MIN_LEN) ? MIN_LEN : cap_len;
  end

  assign byte_stream.ready = !busy[fill_bank] && job_ready;
  assign accept    = byte_stream.valid && byte_stream.ready;
  assign base      = byte_stream.first_byte ? '0 : count;
  assign count_inc = base + 1'b1;
  // A shortened length mid-record still ends the record on the next byte.
  assign done      = CMP_W'(count_inc) >= {1'b0, eff_len};

  assign job_valid = accept && done;
  assign job.bank  = fill_bank;
  assign job.len   = eff_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_len <= CFG_LEN_RESET;
    end else if (cfg_wr_en) begin
      cfg_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      fill_bank <= 1'b0;
      busy      <= '0;
    end else begin
      if (rel.valid) begin
        busy[rel.bank] <= 1'b0;
      end
      if (accept) begin
        if (done) begin
          count           <= '0;
          busy[fill_bank] <= 1'b1;
          fill_bank       <= ~fill_bank;
        end else begin
          count <= count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[{fill_bank, base[IDX_W-1:0]}] <= byte_stream.data_byte;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/asc_job_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of completed records between the byte collector and the parser.
// Depends on asc_pkg for the record descriptor.
module asc_job_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  asc_pkg::job_t push_job,
  output logic          push_ready,
  output logic          pop_valid,
  output asc_pkg::job_t pop_job,
  input  logic          pop_ready
);
  import asc_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] used;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (used != 2'd2);
  assign pop_valid  = (used != 2'd0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      used <= used + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

### rtl/core/asc_back.sv
`timescale 1ns / 1ps
// Parser: walks a stored record one bit per cycle through the field phases and
// holds the decoded result in an output register. Depends on asc_pkg and asc_out_if.
module asc_back #(
  parameter int MAX_RECORD_BYTES = asc_pkg::MAX_RECORD_BYTES_DEF,
  parameter int IDX_W            = $clog2(MAX_RECORD_BYTES)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  input  asc_pkg::job_t               job,
  output logic                        job_pop,
  output logic [IDX_W:0]              rd_addr,
  input  logic [asc_pkg::DATA_W-1:0]  rd_data,
  output asc_pkg::rel_t               rel,
  asc_out_if.source                   result
);
  import asc_pkg::*;

  localparam int RB_W = LEN_W + 3;
  localparam int PW_W = POS_W + IDX_W;

  phase_t             phase, phase_next;
  logic [POS_W-1:0]   bitpos, bitpos_next;
  logic [ACC_W-1:0]   acc, acc_next;
  logic [CNT_W-1:0]   bits_left, bits_left_next;
  logic               bank, bank_next;
  logic [LEN_W-1:0]   len, len_next;

  logic [OBJ_W-1:0]   obj, obj_next;
  logic [RATE_W-1:0]  rate, rate_next;
  logic [CHAN_W-1:0]  chan, chan_next;
  logic [SBR_W-1:0]   sbr, sbr_next;
  logic [RATE_W-1:0]  ext_rate, ext_rate_next;
  logic [OBJ_W-1:0]   ext_obj, ext_obj_next;
  logic [DELAY_W-1:0] delay, delay_next;
  logic [LAYER_W-1:0] layer, layer_next;
  logic [SUBS_W-1:0]  subs, subs_next;
  logic [LLEN_W-1:0]  llen, llen_next;
  logic [RESIL_W-1:0] resil, resil_next;
  logic               trunc, trunc_next;
  logic               ext_flag, ext_flag_next;

  logic               out_valid;
  logic               out_load;
  logic [CNT_W-1:0]   fw;
  logic               reading;
  logic               last;
  logic               in_range;
  logic               cur_bit;
  logic [ACC_W-1:0]   value;
  logic               sync_room;
  logic [PW_W-1:0]    pos_wide;

  assign fw       = field_width(phase);
  assign reading  = (fw != '0);
  assign last     = reading && (bits_left == CNT_W'(1));
  // Bits beyond the record read as zero and mark the result as truncated.
  assign in_range = RB_W'(bitpos) < {len, 3'b000};
  assign cur_bit  = in_range && rd_data[~bitpos[2:0]];
  assign value    = {acc[ACC_W-2:0], cur_bit};
  // The sync extension needs two whole bytes from the one holding the next bit.
  assign sync_room = ({3'b000, bitpos[POS_W-1:3]} + 8'd2) <= {1'b0, len};
  assign out_load  = (phase == P_DONE) && (!out_valid || result.ready);

  always_comb begin : next_phase
    phase_next = phase;
    unique case (phase)
      P_IDLE:       if (job_valid) phase_next = P_OBJ;
      P_OBJ:        if (last) phase_next = P_SFI;
      P_SFI:        if (last) phase_next = (value[3:0] == SFI_EXPLICIT) ? P_RATE : P_CHAN;
      P_RATE:       if (last) phase_next = P_CHAN;
      P_CHAN:       if (last) phase_next = (obj == AOT_SBR) ? P_XSFI : P_GA_CHECK;
      P_XSFI:       if (last) phase_next = (value[3:0] == SFI_EXPLICIT) ? P_XRATE : P_OBJ2;
      P_XRATE:      if (last) phase_next = P_OBJ2;
      P_OBJ2:       if (last) phase_next = P_GA_CHECK;
      P_GA_CHECK:   phase_next = has_ga_config(obj) ? P_FLEN : P_EP_CHECK;
      P_FLEN:       if (last) phase_next = P_DELAY_FLAG;
      P_DELAY_FLAG: if (last) phase_next = value[0] ? P_DELAY : P_EXT_FLAG;
      P_DELAY:      if (last) phase_next = P_EXT_FLAG;
      P_EXT_FLAG: begin
        if (last) begin
          phase_next = ((obj == AOT_AAC_SCAL) || (obj == AOT_ER_SCAL)) ? P_LAYER : P_GA_EXT;
        end
      end
      P_LAYER:      if (last) phase_next = P_GA_EXT;
      P_GA_EXT: begin
        if (!ext_flag) begin
          phase_next = P_EP_CHECK;
        end else if (obj == AOT_ER_BSAC) begin
          phase_next = P_SUBS;
        end else begin
          phase_next = has_resil_flags(obj) ? P_RESIL : P_FLAG3;
        end
      end
      P_SUBS:       if (last) phase_next = P_LLEN;
      P_LLEN:       if (last) phase_next = has_resil_flags(obj) ? P_RESIL : P_FLAG3;
      P_RESIL:      if (last) phase_next = P_FLAG3;
      P_FLAG3:      if (last) phase_next = P_EP_CHECK;
      P_EP_CHECK:   phase_next = has_ep_config(obj) ? P_EP : P_SYNC_CHECK;
      P_EP:         if (last) phase_next = (value[1:0] == EP_DIRECT) ? P_DM : P_SYNC_CHECK;
      P_DM:         if (last) phase_next = P_SYNC_CHECK;
      P_SYNC_CHECK: phase_next = ((ext_obj != AOT_SBR) && sync_room) ? P_SYNC : P_DONE;
      P_SYNC:       if (last) phase_next = (value[10:0] == SYNC_WORD) ? P_XOBJ : P_DONE;
      P_XOBJ:       if (last) phase_next = (value[4:0] == AOT_SBR) ? P_SBR : P_DONE;
      P_SBR:        if (last) phase_next = value[0] ? P_XSFI2 : P_DONE;
      P_XSFI2:      if (last) phase_next = (value[3:0] == SFI_EXPLICIT) ? P_XRATE2 : P_DONE;
      P_XRATE2:     if (last) phase_next = P_DONE;
      P_DONE:       if (out_load) phase_next = P_IDLE;
      default:      phase_next = P_IDLE;
    endcase
  end

  always_comb begin : datapath
    bitpos_next    = bitpos;
    acc_next       = acc;
    bits_left_next = bits_left;
    bank_next      = bank;
    len_next       = len;
    obj_next       = obj;
    rate_next      = rate;
    chan_next      = chan;
    sbr_next       = sbr;
    ext_rate_next  = ext_rate;
    ext_obj_next   = ext_obj;
    delay_next     = delay;
    layer_next     = layer;
    subs_next      = subs;
    llen_next      = llen;
    resil_next     = resil;
    trunc_next     = trunc;
    ext_flag_next  = ext_flag;
    job_pop        = 1'b0;
    rel.valid      = 1'b0;
    rel.bank       = bank;

    if (reading) begin
      bitpos_next = bitpos + 1'b1;
      if (!in_range) begin
        trunc_next = 1'b1;
      end
      if (last) begin
        acc_next = '0;
      end else begin
        acc_next       = value;
        bits_left_next = bits_left - 1'b1;
      end
    end
    if (phase_next != phase) begin
      bits_left_next = field_width(phase_next);
    end

    unique case (phase)
      P_IDLE: begin
        if (job_valid) begin
          job_pop       = 1'b1;
          bank_next     = job.bank;
          len_next      = job.len;
          bitpos_next   = '0;
          acc_next      = '0;
          obj_next      = '0;
          rate_next     = '0;
          chan_next     = '0;
          sbr_next      = SBR_UNKNOWN;
          ext_rate_next = '0;
          ext_obj_next  = '0;
          delay_next    = '0;
          layer_next    = '0;
          subs_next     = '0;
          llen_next     = '0;
          resil_next    = '0;
          trunc_next    = 1'b0;
          ext_flag_next = 1'b0;
        end
      end
      P_OBJ, P_OBJ2: if (last) obj_next = value[OBJ_W-1:0];
      P_SFI: begin
        if (last && (value[3:0] != SFI_EXPLICIT)) rate_next = rate_lookup(value[3:0]);
      end
      P_RATE: if (last) rate_next = value[RATE_W-1:0];
      P_CHAN: begin
        if (last) begin
          chan_next = value[CHAN_W-1:0];
          if (obj == AOT_SBR) begin
            ext_obj_next = AOT_SBR;
            sbr_next     = SBR_YES;
          end
        end
      end
      P_XSFI, P_XSFI2: begin
        if (last && (value[3:0] != SFI_EXPLICIT)) ext_rate_next = rate_lookup(value[3:0]);
      end
      P_XRATE, P_XRATE2: if (last) ext_rate_next = value[RATE_W-1:0];
      P_DELAY:    if (last) delay_next = value[DELAY_W-1:0];
      P_EXT_FLAG: if (last) ext_flag_next = value[0];
      P_LAYER:    if (last) layer_next = value[LAYER_W-1:0];
      P_SUBS:     if (last) subs_next = value[SUBS_W-1:0];
      P_LLEN:     if (last) llen_next = value[LLEN_W-1:0];
      P_RESIL:    if (last) resil_next = {value[2:0], 1'b0};
      P_FLAG3:    if (last) resil_next = {resil[RESIL_W-1:1], value[0]};
      P_XOBJ:     if (last) ext_obj_next = value[OBJ_W-1:0];
      P_SBR:      if (last) sbr_next = {1'b0, value[0]};
      P_DONE:     rel.valid = out_load;
      default: begin
      end
    endcase
  end

  // Byte of the next bit is addressed from bitpos_next, so the data is ready on use.
  assign pos_wide = PW_W'(bitpos_next);
  assign rd_addr  = {bank_next, pos_wide[3 +: IDX_W]};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= P_IDLE;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    bitpos    <= bitpos_next;
    acc       <= acc_next;
    bits_left <= bits_left_next;
    bank      <= bank_next;
    len       <= len_next;
    obj       <= obj_next;
    rate      <= rate_next;
    chan      <= chan_next;
    sbr       <= sbr_next;
    ext_rate  <= ext_rate_next;
    ext_obj   <= ext_obj_next;
    delay     <= delay_next;
    layer     <= layer_next;
    subs      <= subs_next;
    llen      <= llen_next;
    resil     <= resil_next;
    trunc     <= trunc_next;
    ext_flag  <= ext_flag_next;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.object_type     <= obj;
      result.sample_rate     <= rate;
      result.channel_setup   <= chan;
      result.sbr_present     <= sbr;
      result.ext_sample_rate <= ext_rate;
      result.ext_object_type <= ext_obj;
      result.core_delay      <= delay;
      result.layer_number    <= layer;
      result.sub_frame_count <= subs;
      result.layer_len       <= llen;
      result.resilience_bits <= resil;
      result.status          <= trunc;
    end
  end

  assign result.valid = out_valid;

endmodule

### rtl/core/asc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the configuration parser and its bind to the top level.
// Depends on asc_pkg and the assertion macros header.
`include "audio_specific_config_parser_defines.svh"

module asc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [asc_pkg::OBJ_W-1:0]          object_type,
  input logic signed [asc_pkg::SBR_W-1:0]   sbr_present,
  input logic [asc_pkg::RATE_W-1:0]         ext_sample_rate,
  input logic [asc_pkg::OBJ_W-1:0]          ext_object_type,
  input logic [asc_pkg::LLEN_W-1:0]         layer_len
);
  import asc_pkg::*;

  `ASC_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !out_valid, "result valid after reset")

  `ASC_ASSERT_GATED(a_stall_holds, clk, rst, out_valid && !out_ready |=> out_valid && $stable(object_type) && $stable(ext_sample_rate), "stalled result changed")

  `ASC_ASSERT_GATED(a_sbr_code, clk, rst, out_valid |-> sbr_present != SBR_BAD, "sbr_present holds an unused code")

  `ASC_ASSERT_GATED(a_ext_rate_sbr, clk, rst, out_valid && ext_object_type != AOT_SBR |-> ext_sample_rate == '0, "extension rate without SBR extension")

  `ASC_ASSERT_GATED(a_layer_len_bsac, clk, rst, out_valid && object_type != AOT_ER_BSAC |-> layer_len == '0, "layer length outside BSAC")

endmodule

bind audio_specific_config_parser asc_checker u_asc_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .object_type     (result.object_type),
  .sbr_present     (result.sbr_present),
  .ext_sample_rate (result.ext_sample_rate),
  .ext_object_type (result.ext_object_type),
  .layer_len       (result.layer_len)
);

### tb/audio_specific_config_parser_test.sv
`timescale 1ns / 1ps
// Self-checking test of the audio-specific configuration parser: records in, decoded fields out.
// Depends on asc_pkg, asc_ifs and the parser RTL; decoding is predicted locally per record.
module audio_specific_config_parser_test;
  import asc_pkg::*;

  localparam int REC_MAX      = MAX_RECORD_BYTES_DEF;
  localparam int DRAIN_CYCLES = 300;
  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 800;

  typedef struct packed {
    logic [OBJ_W-1:0]   object_type;
    logic [RATE_W-1:0]  sample_rate;
    logic [CHAN_W-1:0]  channel_setup;
    logic [SBR_W-1:0]   sbr_present;
    logic [RATE_W-1:0]  ext_sample_rate;
    logic [OBJ_W-1:0]   ext_object_type;
    logic [DELAY_W-1:0] core_delay;
    logic [LAYER_W-1:0] layer_number;
    logic [SUBS_W-1:0]  sub_frame_count;
    logic [LLEN_W-1:0]  layer_len;
    logic [RESIL_W-1:0] resilience_bits;
    logic               status;
  } decoded_config_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;

  asc_in_if byte_bus();
  asc_out_if result_bus();

  audio_specific_config_parser DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .byte_stream(byte_bus),
    .result(result_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the parser state.
  logic [LEN_W-1:0] cfg_len = CFG_LEN_RESET;
  logic [7:0] rec_mem [REC_MAX];
  int rec_count = 0;
  int rd_pos;
  int rd_end;
  bit rd_past_end;

  decoded_config_t pending_decodes [$];
  int error_count = 0;
  bit hold_request = 1'b0;
  bit paced = 1'b0;
  int burst_left = 0;

  // Record under construction for the stimulus.
  logic [7:0] build_buf [REC_MAX];
  int build_pos;

  function automatic int clamp_len(input logic [LEN_W-1:0] n);
    if (n < MIN_LEN) return 2;
    if (n > REC_MAX) return REC_MAX;
    return int'(n);
  endfunction

  // Bits past the end of the record read as zero and flag the record as truncated.
  function automatic logic [23:0] read_field(input int n);
    logic [23:0] v;
    logic b;
    v = '0;
    for (int i = 0; i < n; i++) begin
      b = 1'b0;
      if (rd_pos < rd_end) begin
        if ((rd_pos >> 3) < REC_MAX) b = rec_mem[rd_pos >> 3][7 - (rd_pos & 7)];
      end else begin
        rd_past_end = 1'b1;
      end
      rd_pos++;
      v = {v[22:0], b};
    end
    return v;
  endfunction

  function automatic logic [RATE_W-1:0] index_to_rate(input logic [3:0] idx);
    logic [RATE_W-1:0] r;
    if (idx == SFI_EXPLICIT) return read_field(24);
    case (idx)
      4'd0:    r = 24'd96000;
      4'd1:    r = 24'd88200;
      4'd2:    r = 24'd64000;
      4'd3:    r = 24'd48000;
      4'd4:    r = 24'd44100;
      4'd5:    r = 24'd32000;
      4'd6:    r = 24'd24000;
      4'd7:    r = 24'd22050;
      4'd8:    r = 24'd16000;
      4'd9:    r = 24'd12000;
      4'd10:   r = 24'd11025;
      4'd11:   r = 24'd8000;
      4'd12:   r = 24'd7350;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic bit carries_ga(input logic [OBJ_W-1:0] t);
    return t == AOT_AAC_MAIN || t == AOT_AAC_LC || t == AOT_AAC_SSR || t == AOT_AAC_LTP ||
           t == AOT_AAC_SCAL || t == AOT_TWINVQ || t == AOT_ER_LC || t == AOT_ER_LTP ||
           t == AOT_ER_SCAL || t == AOT_ER_TWINVQ || t == AOT_ER_BSAC || t == AOT_ER_LD;
  endfunction

  function automatic bit carries_ep(input logic [OBJ_W-1:0] t);
    return t == AOT_ER_LC || (t >= AOT_ER_LTP && t <= AOT_ER_PARAM);
  endfunction

  function automatic bit carries_resil(input logic [OBJ_W-1:0] t);
    return t == AOT_ER_LC || t == AOT_ER_LTP || t == AOT_ER_SCAL || t == AOT_ER_LD;
  endfunction

  function automatic decoded_config_t decode_record(input int len);
    decoded_config_t d;
    logic [OBJ_W-1:0] obj;
    logic ext_flag;
    int byte_at;
    d = '0;
    d.sbr_present = SBR_UNKNOWN;
    rd_pos = 0;
    rd_end = len * 8;
    rd_past_end = 1'b0;

    obj = 5'(read_field(5));
    d.sample_rate = index_to_rate(4'(read_field(4)));
    d.channel_setup = 4'(read_field(4));

    if (obj == AOT_SBR) begin
      d.ext_object_type = AOT_SBR;
      d.sbr_present = SBR_YES;
      d.ext_sample_rate = index_to_rate(4'(read_field(4)));
      obj = 5'(read_field(5));
    end

    if (carries_ga(obj)) begin
      void'(read_field(1));
      if (read_field(1) != 0) d.core_delay = 14'(read_field(14));
      ext_flag = read_field(1) != 0;
      if (obj == AOT_AAC_SCAL || obj == AOT_ER_SCAL) d.layer_number = 3'(read_field(3));
      if (ext_flag) begin
        if (obj == AOT_ER_BSAC) begin
          d.sub_frame_count = 5'(read_field(5));
          d.layer_len = 11'(read_field(11));
        end
        if (carries_resil(obj)) d.resilience_bits = {3'(read_field(3)), 1'b0};
        d.resilience_bits[0] = read_field(1) != 0;
      end
    end

    if (carries_ep(obj)) begin
      if (2'(read_field(2)) == EP_DIRECT) void'(read_field(2));
    end

    // The sync extension is only looked for without an explicit SBR header,
    // and only while at least two bytes remain from the current byte.
    if (d.ext_object_type != AOT_SBR) begin
      byte_at = rd_pos >> 3;
      if (byte_at <= len && len - byte_at >= 2) begin
        if (11'(read_field(11)) == SYNC_WORD) begin
          d.ext_object_type = 5'(read_field(5));
          if (d.ext_object_type == AOT_SBR) begin
            d.sbr_present = 2'(read_field(1));
            if (d.sbr_present == SBR_YES)
              d.ext_sample_rate = index_to_rate(4'(read_field(4)));
          end
        end
      end
    end

    d.object_type = obj;
    d.status = rd_past_end;
    return d;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic f);
    int len_eff;
    len_eff = clamp_len(cfg_len);
    if (f) rec_count = 0;
    if (rec_count < REC_MAX) begin
      rec_mem[rec_count] = b;
      rec_count++;
    end
    if (rec_count >= len_eff) begin
      pending_decodes.push_back(decode_record(len_eff));
      rec_count = 0;
    end
  endtask

  // ---------------------------------------------------------------- driving

  task automatic send_byte(input logic [7:0] b, input logic f);
    byte_bus.valid <= 1'b1;
    byte_bus.data_byte <= b;
    byte_bus.first_byte <= f;
    @(posedge clk);
    while (!byte_bus.ready) @(posedge clk);
    predict_byte(b, f);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        byte_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
  endtask

  task automatic wait_idle();
    byte_bus.valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_len = v;
    @(posedge clk);
  endtask

  task automatic start_record();
    for (int i = 0; i < REC_MAX; i++) build_buf[i] = 8'($urandom);
    build_pos = 0;
  endtask

  task automatic put_bits(input int n, input logic [23:0] v);
    for (int i = n - 1; i >= 0; i--) begin
      if ((build_pos >> 3) < REC_MAX) build_buf[build_pos >> 3][7 - (build_pos & 7)] = v[i];
      build_pos++;
    end
  endtask

  task automatic send_record(input int nbytes, input logic mark_first);
    for (int i = 0; i < nbytes; i++) begin
      if (paced) pace_sender();
      send_byte(build_buf[i], mark_first && i == 0);
    end
  endtask

  // Explicit rates are drawn about a quarter of the time.
  task automatic put_rate_index();
    logic [3:0] idx;
    idx = ($urandom_range(0, 3) == 0) ? SFI_EXPLICIT : 4'($urandom_range(0, 14));
    put_bits(4, idx);
    if (idx == SFI_EXPLICIT) put_bits(24, $urandom);
  endtask

  function automatic logic [OBJ_W-1:0] pick_ga_type();
    case ($urandom_range(0, 11))
      0:       return AOT_AAC_MAIN;
      1:       return AOT_AAC_LC;
      2:       return AOT_AAC_SSR;
      3:       return AOT_AAC_LTP;
      4:       return AOT_AAC_SCAL;
      5:       return AOT_TWINVQ;
      6:       return AOT_ER_LC;
      7:       return AOT_ER_LTP;
      8:       return AOT_ER_SCAL;
      9:       return AOT_ER_TWINVQ;
      10:      return AOT_ER_BSAC;
      default: return AOT_ER_LD;
    endcase
  endfunction

  // Lays out a well-formed record with random field contents over random filler.
  task automatic build_random_record();
    logic [OBJ_W-1:0] outer;
    logic [OBJ_W-1:0] inner;
    logic [OBJ_W-1:0] xo;
    logic [1:0] ep;
    bit df;
    bit ef;
    bit sb;
    case ($urandom_range(0, 9))
      6, 9:    outer = AOT_SBR;
      7:       outer = 5'($urandom_range(AOT_ER_PARAM - 3, AOT_ER_PARAM));
      8:       outer = 5'($urandom);
      default: outer = pick_ga_type();
    endcase
    start_record();
    put_bits(5, outer);
    put_rate_index();
    put_bits(4, $urandom);
    inner = outer;
    if (outer == AOT_SBR) begin
      put_rate_index();
      inner = ($urandom_range(0, 4) == 0) ? 5'($urandom) : pick_ga_type();
      put_bits(5, inner);
    end
    if (carries_ga(inner)) begin
      put_bits(1, $urandom);
      df = $urandom_range(0, 1);
      put_bits(1, df);
      if (df) put_bits(14, $urandom);
      ef = $urandom_range(0, 1);
      put_bits(1, ef);
      if (inner == AOT_AAC_SCAL || inner == AOT_ER_SCAL) put_bits(3, $urandom);
      if (ef) begin
        if (inner == AOT_ER_BSAC) begin
          put_bits(5, $urandom);
          put_bits(11, $urandom);
        end
        if (carries_resil(inner)) put_bits(3, $urandom);
        put_bits(1, $urandom);
      end
    end
    if (carries_ep(inner)) begin
      ep = ($urandom_range(0, 1) == 0) ? EP_DIRECT : 2'($urandom);
      put_bits(2, ep);
      if (ep == EP_DIRECT) put_bits(2, $urandom);
    end
    if (outer != AOT_SBR && $urandom_range(0, 3) != 0) begin
      put_bits(11, SYNC_WORD);
      xo = ($urandom_range(0, 2) != 0) ? AOT_SBR : 5'($urandom);
      put_bits(5, xo);
      if (xo == AOT_SBR) begin
        sb = $urandom_range(0, 3) != 0;
        put_bits(1, sb);
        if (sb) put_rate_index();
      end
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic field_check(input string name, input logic [23:0] want, input logic [23:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result(input decoded_config_t e);
    field_check("object_type", e.object_type, result_bus.object_type);
    field_check("sample_rate", e.sample_rate, result_bus.sample_rate);
    field_check("channel_setup", e.channel_setup, result_bus.channel_setup);
    field_check("sbr_present", e.sbr_present, $unsigned(result_bus.sbr_present));
    field_check("ext_sample_rate", e.ext_sample_rate, result_bus.ext_sample_rate);
    field_check("ext_object_type", e.ext_object_type, result_bus.ext_object_type);
    field_check("core_delay", e.core_delay, result_bus.core_delay);
    field_check("layer_number", e.layer_number, result_bus.layer_number);
    field_check("sub_frame_count", e.sub_frame_count, result_bus.sub_frame_count);
    field_check("layer_len", e.layer_len, result_bus.layer_len);
    field_check("resilience_bits", e.resilience_bits, result_bus.resilience_bits);
    field_check("status", e.status, result_bus.status);
  endtask

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_decodes.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result transaction, object_type %0h", $time,
                 result_bus.object_type);
      end else begin
        check_result(pending_decodes.pop_front());
      end
    end
  end

  // Receiver: changes between always ready, coin-toss and mostly stalled,
  // and holds off completely when a test asks for it.
  initial begin
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        result_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 150);
        end
        mode_left--;
        case (mode)
          0:       result_bus.ready <= 1'b1;
          1:       result_bus.ready <= 1'($urandom_range(0, 1));
          default: result_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < IDLE_LIMIT) begin
      @(posedge clk);
      if ((byte_bus.valid && byte_bus.ready) || (result_bus.valid && result_bus.ready))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------- tests

  // Default length of two bytes, bytes sent without a start mark.
  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    // Object type 31 with an explicit rate that runs off the end.
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    wait_idle();
  endtask

  task automatic test_header_and_sync();
    write_length(7'd7);
    start_record();
    put_bits(5, AOT_AAC_LC);
    put_bits(4, 4'd3);
    put_bits(4, 4'd2);
    put_bits(1, 1'b0);
    put_bits(1, 1'b1);
    put_bits(14, 14'h3FFF);
    put_bits(1, 1'b0);
    put_bits(11, SYNC_WORD);
    put_bits(5, AOT_SBR);
    put_bits(1, 1'b1);
    put_bits(4, 4'd6);
    send_record(7, 1'b1);
    wait_idle();
  endtask

  // Explicit SBR header with explicit core rate, reserved extension index, BSAC fields
  // and a direct-mapped error-protection config.
  task automatic test_explicit_sbr();
    write_length(7'd9);
    start_record();
    put_bits(5, AOT_SBR);
    put_bits(4, SFI_EXPLICIT);
    put_bits(24, 24'hFFFFFF);
    put_bits(4, 4'hF);
    put_bits(4, 4'd13);
    put_bits(5, AOT_ER_BSAC);
    put_bits(1, 1'b1);
    put_bits(1, 1'b0);
    put_bits(1, 1'b1);
    put_bits(5, 5'h1F);
    put_bits(11, 11'h7FF);
    put_bits(1, 1'b1);
    put_bits(2, EP_DIRECT);
    put_bits(2, 2'd2);
    send_record(9, 1'b1);
    wait_idle();
  endtask

  // Scalable record whose resilience flags fall past the last byte.
  task automatic test_truncated_record();
    write_length(7'd4);
    start_record();
    put_bits(5, AOT_ER_SCAL);
    put_bits(4, 4'd12);
    put_bits(4, 4'd0);
    put_bits(1, 1'b0);
    put_bits(1, 1'b1);
    put_bits(14, 14'h1555);
    put_bits(1, 1'b1);
    put_bits(3, 3'd7);
    send_record(4, 1'b1);
    wait_idle();
  endtask

  task automatic test_length_change();
    write_length(7'd8);
    start_record();
    send_record(3, 1'b1);
    wait_idle();
    // Shrinking the length to the number of bytes already held completes the record
    // on the next transaction.
    write_length(7'd3);
    send_byte(8'($urandom), 1'b0);
    wait_idle();
    write_length(7'd0);
    start_record();
    send_record(2, 1'b1);
    wait_idle();
  endtask

  task automatic test_backpressure();
    write_length(7'd2);
    hold_request = 1'b1;
    for (int r = 0; r < 24; r++) begin
      start_record();
      send_record(2, 1'b1);
    end
    wait_idle();
  endtask

  task automatic test_random_records();
    int phase_len [12];
    int phase_recs [12];
    int eff;
    int kind;
    phase_len = '{2, 3, 5, 8, 10, 12, 16, 64, 1, 0, 127, 9};
    phase_recs = '{15, 10, 8, 8, 6, 5, 3, 1, 8, 4, 1, 6};
    for (int p = 0; p < 12; p++) begin
      write_length(7'(phase_len[p]));
      eff = clamp_len(7'(phase_len[p]));
      paced = $urandom_range(0, 3) != 0;
      burst_left = 0;
      for (int r = 0; r < phase_recs[p]; r++) begin
        kind = $urandom_range(0, 7);
        start_record();
        if (kind == 0) begin
          send_record(eff, 1'b1);
        end else begin
          // An abandoned partial record, restarted by the start mark.
          if (kind == 1) send_record($urandom_range(1, eff - 1), 1'b1);
          build_random_record();
          send_record(eff, kind == 1 || $urandom_range(0, 5) != 0);
        end
      end
      wait_idle();
    end
    paced = 1'b0;
  endtask

  initial begin
    byte_bus.valid = 1'b0;
    byte_bus.data_byte = '0;
    byte_bus.first_byte = 1'b0;
    for (int i = 0; i < REC_MAX; i++) rec_mem[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    repeat (5) @(posedge clk);

    test_reset_defaults();
    test_header_and_sync();
    test_explicit_sbr();
    test_truncated_record();
    test_length_change();
    test_backpressure();
    test_random_records();
    wait_idle();

    if (error_count == 0 && pending_decodes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/asc_pkg.sv
rtl/core/asc_ifs.sv
rtl/core/asc_front.sv
rtl/core/asc_job_queue.sv
rtl/core/asc_back.sv
rtl/core/audio_specific_config_parser.sv
rtl/core/asc_checker.sv
tb/audio_specific_config_parser_test.sv
